[src/rrli_pkg.sv]
// shared constants, types and helpers for the round-robin list interleaver
`default_nettype none

package rrli_pkg;

    localparam int LIST_COUNT = 8;
    localparam int LIST_DEPTH = 32;

    localparam int LIST_W  = $clog2(LIST_COUNT);
    localparam int CNT_W   = $clog2(LIST_DEPTH + 1);
    localparam int POS_W   = $clog2(LIST_DEPTH);
    localparam int STORE_D = LIST_COUNT * LIST_DEPTH;
    localparam int ADDR_W  = $clog2(STORE_D);

    localparam int VALUE_W   = 32;
    localparam int IDX_W     = 3;
    localparam int CMD_W     = 2;
    localparam int S_TDATA_W = 40;
    localparam int M_TDATA_W = 40;
    localparam int M_TUSER_W = 2;

    typedef enum logic [CMD_W-1:0] {
        CMD_PUSH  = 2'd0,
        CMD_PULL  = 2'd1,
        CMD_CLEAR = 2'd2,
        CMD_NOP   = 2'd3
    } cmd_t;

    // result of the rotating priority search
    typedef struct packed {
        logic              hit;
        logic [LIST_W-1:0] list;
    } pick_t;

    // side information of a pull waiting for its store read
    typedef struct packed {
        logic              empty;
        logic              last;
        logic              ovf;
        logic [LIST_W-1:0] src;
    } pend_t;

    function automatic logic [ADDR_W-1:0] store_addr(input logic [LIST_W-1:0] list,
                                                     input logic [POS_W-1:0]  pos);
        store_addr = ADDR_W'(list) * ADDR_W'(LIST_DEPTH) + ADDR_W'(pos);
    endfunction

endpackage

`default_nettype wire

[src/rrli_ram.sv]
// generic single-clock ram, one write port, one registered read port
`default_nettype none

module rrli_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256,
    localparam int AW = $clog2(DEPTH)
) (
    input  wire logic             aclk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    waddr,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic             re,
    input  wire logic [AW-1:0]    raddr,
    output logic      [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

[src/rrli_rr_pick.sv]
// rotating priority search over the per-list non-empty flags
`default_nettype none

module rrli_rr_pick
    import rrli_pkg::*;
(
    input  wire logic [LIST_COUNT-1:0] flags,
    input  wire logic [LIST_W-1:0]     start,
    output pick_t                      pick
);

    always_comb begin
        int l;
        pick = '0;
        for (int k = 0; k < LIST_COUNT; k++) begin
            l = int'(start) + k;
            if (l >= LIST_COUNT) begin
                l = l - LIST_COUNT;
            end
            if (!pick.hit && flags[l]) begin
                pick.hit  = 1'b1;
                pick.list = LIST_W'(l);
            end
        end
    end

endmodule

`default_nettype wire

[src/round_robin_list_interleaver_core.sv]
// top level of the round-robin list interleaver
//
// usage
//   s_ channel: one beat per command. s_tuser carries the command (push, pull,
//   clear, no operation), s_tdata the target list and the value of a push.
//   m_ channel: one beat for every pull, nothing for the other commands.
//   m_tdata holds the element and the list it came from, m_tuser the empty
//   and sticky overflow flags, m_tlast marks the final remaining element.
// timing
//   push, clear and no operation complete in the accept cycle. a pull goes in
//   steps: the search and the element store read in the accept cycle, then the
//   registered read data moves into the output register once that is free, and
//   m_tvalid rises with that move. no command is taken while a pull waits.
// reset
//   aresetn low clears all list counters, the round-robin pointer and the
//   overflow flag; the element store itself holds no reset, only written
//   entries are ever read.
// stall
//   while a result waits in the output register the next command is still
//   taken; a pull whose read data cannot move on holds s_tready low.
`default_nettype none

module round_robin_list_interleaver_core
    import rrli_pkg::*;
(
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    // s_tdata: list_index[2:0], value[34:3], zero fill[39:35]
    input  wire logic [S_TDATA_W-1:0] s_tdata,
    // s_tuser: command[1:0]
    input  wire logic [CMD_W-1:0]     s_tuser,
    input  wire logic                 s_tvalid,
    output logic                      s_tready,
    // m_tdata: value_out[31:0], source_list[34:32], zero fill[39:35]
    output logic [M_TDATA_W-1:0]      m_tdata,
    // m_tuser: empty_res[0], overflow_seen[1]
    output logic [M_TUSER_W-1:0]      m_tuser,
    output logic                      m_tlast,
    output logic                      m_tvalid,
    input  wire logic                 m_tready
);

    // per-list counters and round-robin state
    logic [CNT_W-1:0]  fill_reg  [LIST_COUNT];
    logic [CNT_W-1:0]  fill_next [LIST_COUNT];
    logic [CNT_W-1:0]  rpos_reg  [LIST_COUNT];
    logic [CNT_W-1:0]  rpos_next [LIST_COUNT];
    logic [LIST_W-1:0] ptr_reg, ptr_next;
    logic              ovf_reg, ovf_next;

    // pull waiting for its store read, and the output register
    logic              pend_reg;
    pend_t             pend_info_reg, pend_info_next;
    logic              out_valid_reg;
    logic [VALUE_W-1:0] out_value_reg;
    pend_t             out_info_reg;

    cmd_t              cmd;
    logic              accept;
    logic [IDX_W-1:0]  in_idx;
    logic [VALUE_W-1:0] in_value;
    logic              idx_ok;
    logic [LIST_W-1:0] push_list;
    logic [LIST_COUNT-1:0] flags;
    logic [LIST_COUNT-1:0] flags_after;
    pick_t             pick;
    logic              still_left;
    logic              push_do;
    logic              pull_do;
    logic              move_out;

    logic              ram_we;
    logic [ADDR_W-1:0] ram_waddr;
    logic [ADDR_W-1:0] ram_raddr;
    logic [VALUE_W-1:0] ram_rdata;

    assign cmd      = cmd_t'(s_tuser);
    assign s_tready = !pend_reg;
    assign accept   = s_tvalid && s_tready;
    assign in_idx   = s_tdata[IDX_W-1:0];
    assign in_value = s_tdata[IDX_W +: VALUE_W];

    // list numbers past the configured count are ignored
    assign idx_ok    = 32'(in_idx) < 32'(LIST_COUNT);
    assign push_list = LIST_W'(in_idx);

    // a list has unread elements while its read position trails its fill
    always_comb begin
        for (int l = 0; l < LIST_COUNT; l++) begin
            flags[l] = rpos_reg[l] < fill_reg[l];
        end
    end

    rrli_rr_pick u_pick (
        .flags (flags),
        .start (ptr_reg),
        .pick  (pick)
    );

    // does the served list keep elements after this pull
    assign still_left = ({1'b0, rpos_reg[pick.list]} + (CNT_W + 1)'(1))
                        < {1'b0, fill_reg[pick.list]};

    always_comb begin
        for (int l = 0; l < LIST_COUNT; l++) begin
            flags_after[l] = (LIST_W'(l) == pick.list) ? still_left : flags[l];
        end
    end

    assign push_do = accept && (cmd == CMD_PUSH) && idx_ok
                     && (fill_reg[push_list] != CNT_W'(LIST_DEPTH));
    assign pull_do = accept && (cmd == CMD_PULL);

    // element store: pushes write, pulls read at the served list's position
    assign ram_we    = push_do;
    assign ram_waddr = store_addr(push_list, POS_W'(fill_reg[push_list]));
    assign ram_raddr = store_addr(pick.list, POS_W'(rpos_reg[pick.list]));

    rrli_ram #(
        .WIDTH (VALUE_W),
        .DEPTH (STORE_D)
    ) u_store (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (in_value),
        .re    (pull_do && pick.hit),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // counter and pointer updates
    always_comb begin
        for (int l = 0; l < LIST_COUNT; l++) begin
            fill_next[l] = fill_reg[l];
            rpos_next[l] = rpos_reg[l];
        end
        ptr_next       = ptr_reg;
        ovf_next       = ovf_reg;
        pend_info_next = pend_info_reg;

        if (accept) begin
            case (cmd)
                CMD_PUSH: begin
                    if (idx_ok) begin
                        if (fill_reg[push_list] == CNT_W'(LIST_DEPTH)) begin
                            ovf_next = 1'b1;
                        end else begin
                            fill_next[push_list] = fill_reg[push_list] + CNT_W'(1);
                        end
                    end
                end
                CMD_PULL: begin
                    pend_info_next.ovf = ovf_reg;
                    if (pick.hit) begin
                        rpos_next[pick.list] = rpos_reg[pick.list] + CNT_W'(1);
                        if (pick.list == LIST_W'(LIST_COUNT - 1)) begin
                            ptr_next = '0;
                        end else begin
                            ptr_next = pick.list + LIST_W'(1);
                        end
                        pend_info_next.empty = 1'b0;
                        pend_info_next.last  = ~|flags_after;
                        pend_info_next.src   = pick.list;
                    end else begin
                        pend_info_next.empty = 1'b1;
                        pend_info_next.last  = 1'b0;
                        pend_info_next.src   = '0;
                    end
                end
                CMD_CLEAR: begin
                    for (int l = 0; l < LIST_COUNT; l++) begin
                        fill_next[l] = '0;
                        rpos_next[l] = '0;
                    end
                    ptr_next = '0;
                end
                default: begin
                end
            endcase
        end
    end

    // pending pull moves on once the output register is free
    assign move_out = pend_reg && (!out_valid_reg || m_tready);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int l = 0; l < LIST_COUNT; l++) begin
                fill_reg[l] <= '0;
                rpos_reg[l] <= '0;
            end
            ptr_reg       <= '0;
            ovf_reg       <= 1'b0;
            pend_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            for (int l = 0; l < LIST_COUNT; l++) begin
                fill_reg[l] <= fill_next[l];
                rpos_reg[l] <= rpos_next[l];
            end
            ptr_reg <= ptr_next;
            ovf_reg <= ovf_next;
            if (pull_do) begin
                pend_reg <= 1'b1;
            end else if (move_out) begin
                pend_reg <= 1'b0;
            end
            if (move_out) begin
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        pend_info_reg <= pend_info_next;
        if (move_out) begin
            out_value_reg <= pend_info_reg.empty ? '0 : ram_rdata;
            out_info_reg  <= pend_info_reg;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {(M_TDATA_W - VALUE_W - IDX_W)'(0),
                       IDX_W'(out_info_reg.src), out_value_reg};
    assign m_tuser  = {out_info_reg.ovf, out_info_reg.empty};
    assign m_tlast  = out_info_reg.last;

endmodule

`default_nettype wire

[src/rrli_checker.sv]
// port-level checks of the interleaver, bound to the top level
`default_nettype none

module rrli_checker
    import rrli_pkg::*;
(
    input wire logic                 aclk,
    input wire logic                 aresetn,
    input wire logic [M_TDATA_W-1:0] m_tdata,
    input wire logic [M_TUSER_W-1:0] m_tuser,
    input wire logic                 m_tlast,
    input wire logic                 m_tvalid,
    input wire logic                 m_tready
);

    // a stalled result beat holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser)
            && $stable(m_tlast))
        else $error("result beat changed while stalled");

    // an empty pull carries no element, no source and no last mark
    a_empty_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser[0] |-> m_tdata[34:0] == 35'd0 && !m_tlast)
        else $error("empty result with nonzero payload");

    // last is only given with a real element
    a_last_not_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tlast |-> !m_tuser[0])
        else $error("last marked on an empty result");

    // reset drops any pending result
    a_reset_idle: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid right after reset");

endmodule

bind round_robin_list_interleaver_core rrli_checker u_rrli_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready)
);

`default_nettype wire

[sim/tb_top.sv]
// self-checking testbench of the round-robin list interleaver: directed table, random command runs
`default_nettype none

module tb_top
    import rrli_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int          HOLD_CYCLES = 200;
    localparam int unsigned CYCLE_LIMIT = 400000;
    localparam int          DIR_ROWS    = 24;
    localparam int          PAD_W       = S_TDATA_W - VALUE_W - IDX_W;

    // one pull beat as seen on the m_ side
    typedef struct packed {
        logic [VALUE_W-1:0] value;
        logic [LIST_W-1:0]  src;
        logic               empty;
        logic               last;
        logic               ovf;
    } pull_result_t;

    // one row of the directed table, want is used only where typed is set
    typedef struct packed {
        cmd_t               cmd;
        logic [IDX_W-1:0]   idx;
        logic [VALUE_W-1:0] val;
        logic               typed;
        pull_result_t       want;
    } stim_row_t;

    localparam pull_result_t RES_NONE      = '0;
    localparam pull_result_t RES_EMPTY     = '{value: '0, src: '0, empty: 1'b1,
                                               last: 1'b0, ovf: 1'b0};
    localparam pull_result_t RES_EMPTY_OVF = '{value: '0, src: '0, empty: 1'b1,
                                               last: 1'b0, ovf: 1'b1};

    logic                 aclk;
    logic                 aresetn;
    logic [S_TDATA_W-1:0] s_tdata;
    logic [CMD_W-1:0]     s_tuser;
    logic                 s_tvalid;
    logic                 s_tready;
    logic [M_TDATA_W-1:0] m_tdata;
    logic [M_TUSER_W-1:0] m_tuser;
    logic                 m_tlast;
    logic                 m_tvalid;
    logic                 m_tready;

    // shadow copy of the lists
    logic [VALUE_W-1:0] list_store [LIST_COUNT][LIST_DEPTH];
    logic [CNT_W-1:0]   fill_cnt   [LIST_COUNT];
    logic [CNT_W-1:0]   read_cnt   [LIST_COUNT];
    logic [LIST_W-1:0]  rr_ptr;
    logic               ovf_sticky;

    pull_result_t expected_pulls [$];
    stim_row_t    dir_rows [DIR_ROWS];

    int          items_taken;
    int          mismatch_count = 0;
    int unsigned cycle_count = 0;
    bit          tx_quiet;
    bit          rx_quiet;
    bit          rx_hold_req;
    pull_result_t seen_pull;
    pull_result_t want_pull;

    round_robin_list_interleaver_core u_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready)
    );

    initial begin
        aclk = 1'b0;
        forever #10 aclk = ~aclk;
    end

    // applies one command to the shadow lists, returns 1 when a pull beat is due
    function automatic bit advance_lists(input cmd_t cmd, input logic [IDX_W-1:0] idx,
                                         input logic [VALUE_W-1:0] val,
                                         output pull_result_t res);
        int                k;
        logic [LIST_W-1:0] l;
        bit                found;
        bit                remaining;
        res = RES_NONE;
        case (cmd)
            CMD_PUSH: begin
                if (int'(idx) < LIST_COUNT) begin
                    if (fill_cnt[idx] == CNT_W'(LIST_DEPTH)) begin
                        ovf_sticky = 1'b1;   // full list, beat dropped
                    end else begin
                        list_store[idx][fill_cnt[idx][POS_W-1:0]] = val;
                        fill_cnt[idx] = fill_cnt[idx] + 1'b1;
                    end
                end
                return 1'b0;
            end
            CMD_CLEAR: begin
                for (k = 0; k < LIST_COUNT; k++) begin
                    fill_cnt[k] = '0;
                    read_cnt[k] = '0;
                end
                rr_ptr = '0;   // sticky overflow survives a clear
                return 1'b0;
            end
            CMD_PULL: begin
                found = 1'b0;
                l     = '0;
                for (k = 0; k < LIST_COUNT && !found; k++) begin
                    l = LIST_W'((int'(rr_ptr) + k) % LIST_COUNT);
                    if (read_cnt[l] < fill_cnt[l])
                        found = 1'b1;
                end
                res.ovf = ovf_sticky;
                if (!found) begin
                    res.empty = 1'b1;   // pointer stays where it is
                    return 1'b1;
                end
                res.value   = list_store[l][read_cnt[l][POS_W-1:0]];
                res.src     = l;
                read_cnt[l] = read_cnt[l] + 1'b1;
                rr_ptr      = LIST_W'((int'(l) + 1) % LIST_COUNT);
                remaining   = 1'b0;
                for (k = 0; k < LIST_COUNT; k++) begin
                    if (read_cnt[k] < fill_cnt[k])
                        remaining = 1'b1;
                end
                res.last = !remaining;
                return 1'b1;
            end
            default: return 1'b0;
        endcase
    endfunction

    function automatic logic [VALUE_W-1:0] pick_value();
        case ($urandom_range(0, 9))
            0:       return 32'h0000_0000;
            1:       return 32'h7fff_ffff;
            2:       return 32'h8000_0000;
            3:       return 32'hffff_ffff;
            default: return $urandom();
        endcase
    endfunction

    // offers one beat after a random gap, updates the shadow lists on accept
    task automatic issue(input cmd_t cmd, input logic [IDX_W-1:0] idx,
                         input logic [VALUE_W-1:0] val, input bit typed,
                         input pull_result_t want);
        int           gap;
        bit           has_res;
        pull_result_t res;
        gap = tx_quiet ? 0 : $urandom_range(0, 15);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= cmd;
        s_tdata  <= {{PAD_W{1'b0}}, val, idx};
        do @(posedge aclk); while (!s_tready);
        has_res = advance_lists(cmd, idx, val, res);
        if (has_res)
            expected_pulls.push_back(typed ? want : res);
        if (cmd != CMD_NOP)
            items_taken++;
    endtask

    task automatic issue_noise();
        issue(cmd_t'($urandom_range(0, 3)), IDX_W'($urandom_range(0, 7)), pick_value(),
              1'b0, RES_NONE);
    endtask

    // sender pause until every pull beat has come back
    task automatic wait_for_results();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (expected_pulls.size() != 0) @(posedge aclk);
    endtask

    // fill a few lists with a bias towards one of them, then drain part or all
    task automatic run_episode();
        int                n_fill;
        int                n_pull;
        int                i;
        logic [IDX_W-1:0]  focus;
        tx_quiet = ($urandom_range(0, 3) == 0);
        rx_quiet = ($urandom_range(0, 3) == 0);
        if ($urandom_range(0, 2) == 0)
            issue(CMD_CLEAR, IDX_W'($urandom_range(0, 7)), pick_value(), 1'b0, RES_NONE);
        focus  = IDX_W'($urandom_range(0, 7));
        n_fill = $urandom_range(1, 24);
        for (i = 0; i < n_fill; i++) begin
            if ($urandom_range(0, 9) == 0)
                issue_noise();
            else if ($urandom_range(0, 2) == 0)
                issue(CMD_PUSH, IDX_W'($urandom_range(0, 7)), pick_value(), 1'b0, RES_NONE);
            else
                issue(CMD_PUSH, focus, pick_value(), 1'b0, RES_NONE);
        end
        n_pull = $urandom_range(1, n_fill + 3);
        for (i = 0; i < n_pull; i++) begin
            if ($urandom_range(0, 7) == 0)
                issue_noise();
            else
                issue(CMD_PULL, IDX_W'($urandom_range(0, 7)), pick_value(), 1'b0, RES_NONE);
        end
    endtask

    // m_ side: random stall per beat, long hold when asked
    initial begin
        int stall;
        m_tready <= 1'b0;
        while (aresetn !== 1'b1) @(posedge aclk);
        forever begin
            if (rx_hold_req) begin
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
                rx_hold_req = 1'b0;
            end
            stall = rx_quiet ? 0 : $urandom_range(0, 15);
            if (stall > 0) begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_tready <= 1'b1;
            do @(posedge aclk); while (!m_tvalid);
        end
    end

    // pull beat checker
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            seen_pull = '{value: m_tdata[VALUE_W-1:0],
                          src:   m_tdata[VALUE_W +: LIST_W],
                          empty: m_tuser[0],
                          last:  m_tlast,
                          ovf:   m_tuser[1]};
            if (expected_pulls.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("unexpected pull beat: value %h src %0d empty %b last %b ovf %b",
                             seen_pull.value, seen_pull.src, seen_pull.empty,
                             seen_pull.last, seen_pull.ovf);
            end else begin
                want_pull = expected_pulls.pop_front();
                if (seen_pull !== want_pull) begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display({"pull mismatch: expected value %h src %0d empty %b last %b",
                                  " ovf %b, got value %h src %0d empty %b last %b ovf %b"},
                                 want_pull.value, want_pull.src, want_pull.empty,
                                 want_pull.last, want_pull.ovf, seen_pull.value,
                                 seen_pull.src, seen_pull.empty, seen_pull.last,
                                 seen_pull.ovf);
                end
            end
        end
    end

    // run limit
    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    initial begin
        int r;
        int i;
        aresetn     <= 1'b0;
        s_tvalid    <= 1'b0;
        s_tdata     <= '0;
        s_tuser     <= CMD_NOP;
        items_taken    = 0;
        tx_quiet    = 1'b0;
        rx_quiet    = 1'b0;
        rx_hold_req = 1'b0;
        for (i = 0; i < LIST_COUNT; i++) begin
            fill_cnt[i] = '0;
            read_cnt[i] = '0;
        end
        rr_ptr     = '0;
        ovf_sticky = 1'b0;

        dir_rows = '{
            '{CMD_PULL,  3'd0, 32'h0000_0000, 1'b1, RES_EMPTY},   // pull right after reset
            '{CMD_NOP,   3'd7, 32'hffff_ffff, 1'b0, RES_NONE},    // no operation, all ones
            '{CMD_PUSH,  3'd0, 32'h7fff_ffff, 1'b0, RES_NONE},
            '{CMD_PUSH,  3'd7, 32'h8000_0000, 1'b0, RES_NONE},
            '{CMD_PUSH,  3'd3, 32'hffff_ffff, 1'b0, RES_NONE},
            '{CMD_PUSH,  3'd7, 32'h0000_0000, 1'b0, RES_NONE},
            '{CMD_PUSH,  3'd0, 32'h0000_0001, 1'b0, RES_NONE},
            '{CMD_PULL,  3'd0, 32'h0000_0000, 1'b0, RES_NONE},    // list 0
            '{CMD_PULL,  3'd0, 32'h0000_0000, 1'b0, RES_NONE},    // skips to list 3
            '{CMD_PULL,  3'd0, 32'h0000_0000, 1'b0, RES_NONE},    // list 7
            '{CMD_PULL,  3'd0, 32'h0000_0000, 1'b0, RES_NONE},    // wraps to list 0
            '{CMD_PULL,  3'd0, 32'h0000_0000, 1'b0, RES_NONE},    // final element, last
            '{CMD_PULL,  3'd0, 32'h0000_0000, 1'b1, RES_EMPTY},   // all drained
            '{CMD_PUSH,  3'd5, 32'h1234_5678, 1'b0, RES_NONE},
            '{CMD_PUSH,  3'd1, 32'ha5a5_a5a5, 1'b0, RES_NONE},
            '{CMD_PULL,  3'd0, 32'h0000_0000, 1'b0, RES_NONE},
            '{CMD_CLEAR, 3'd0, 32'h0000_0000, 1'b0, RES_NONE},    // drops unread list 5
            '{CMD_PULL,  3'd0, 32'h0000_0000, 1'b1, RES_EMPTY},
            '{CMD_PUSH,  3'd6, 32'hdead_beef, 1'b0, RES_NONE},
            '{CMD_PULL,  3'd0, 32'h0000_0000, 1'b0, RES_NONE},
            '{CMD_CLEAR, 3'd7, 32'hffff_ffff, 1'b0, RES_NONE},
            '{CMD_NOP,   3'd0, 32'h0000_0000, 1'b0, RES_NONE},
            '{CMD_PUSH,  3'd4, 32'h5555_5555, 1'b0, RES_NONE},
            '{CMD_PULL,  3'd2, 32'haaaa_aaaa, 1'b0, RES_NONE}
        };

        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed table
        for (r = 0; r < DIR_ROWS; r++)
            issue(dir_rows[r].cmd, dir_rows[r].idx, dir_rows[r].val,
                  dir_rows[r].typed, dir_rows[r].want);
        wait_for_results();

        // random runs, overflow still clear for most of them
        while (items_taken < 250)
            run_episode();
        wait_for_results();

        // receiver holds off while pulls keep coming, input must back up
        tx_quiet    = 1'b1;
        rx_quiet    = 1'b0;
        rx_hold_req = 1'b1;
        for (i = 0; i < 12; i++)
            issue(CMD_PUSH, IDX_W'($urandom_range(0, 7)), pick_value(), 1'b0, RES_NONE);
        for (i = 0; i < 24; i++)
            issue(CMD_PULL, IDX_W'($urandom_range(0, 7)), pick_value(), 1'b0, RES_NONE);
        wait_for_results();

        // fill one list past its depth, then check the flag survives a clear
        tx_quiet = 1'b0;
        issue(CMD_CLEAR, 3'd0, 32'h0, 1'b0, RES_NONE);
        for (i = 0; i < LIST_DEPTH + 2; i++)
            issue(CMD_PUSH, 3'd2, pick_value(), 1'b0, RES_NONE);
        issue(CMD_PULL, 3'd0, 32'h0, 1'b0, RES_NONE);
        issue(CMD_CLEAR, 3'd0, 32'h0, 1'b0, RES_NONE);
        issue(CMD_PULL, 3'd0, 32'h0, 1'b1, RES_EMPTY_OVF);
        wait_for_results();

        while (items_taken < 720)
            run_episode();

        wait_for_results();
        repeat (8) @(posedge aclk);
        if (mismatch_count == 0 && expected_pulls.size() == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule

`default_nettype wire
